FILE: rtl/core/stfp_pkg.sv
// Shared types, constants and helper functions for the status text field parser.
// No dependencies.
package stfp_pkg;

    // Width of a parsed decimal value; longer digit runs saturate.
    localparam int VALUE_BITS = 40;
    localparam int ACC_W      = VALUE_BITS + 4;   // room for value * 10 + 9
    localparam int BYTES_W    = 50;               // resident size outputs
    localparam int THREADS_W  = 40;               // thread count output
    localparam int KB_SHIFT   = 10;               // kilobytes to bytes

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [1:0] {
        PH_MATCH,
        PH_SPACE,
        PH_DIGITS,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KW_NONE,
        KW_RSS,
        KW_HWM,
        KW_THR
    } kw_t;

    localparam int NUM_KW = 3;

    // Keyword spellings, one row per keyword, padded with zeros.
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{8'h56, 8'h6D, 8'h52, 8'h53, 8'h53, 8'h3A, 8'h00, 8'h00},  // VmRSS:
        '{8'h56, 8'h6D, 8'h48, 8'h57, 8'h4D, 8'h3A, 8'h00, 8'h00},  // VmHWM:
        '{8'h54, 8'h68, 8'h72, 8'h65, 8'h61, 8'h64, 8'h73, 8'h3A}   // Threads:
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd6, 4'd8};

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

FILE: rtl/core/status_text_field_parser.sv
// Status text field parser: top level, byte input register, line parser and result register.
// Depends on stfp_pkg.
//
// The block takes a status text one byte per request and splits it into lines at
// newline bytes. A line whose start is exactly "VmRSS:", "VmHWM:" or "Threads:",
// followed by optional blanks and a run of decimal digits, stores that value; a
// later line of the same keyword replaces an earlier one, and a keyword line with
// no digits changes nothing. The request flagged with s_last_byte closes the text
// (a final line without newline counts) and produces exactly one result request:
// resident and peak resident size in bytes (kilobytes times 1024), the thread
// count, and value_overflow, set when any digit run exceeded VALUE_BITS bits and
// saturated. After that result all stored values return to zero. Every other
// byte produces no result. Throughput is one byte per clock cycle, except for the
// stall below: a byte sits in the input register while the parser state update
// (one constant multiply-add by ten and a compare) runs, and for a last byte the
// result then lands in the output register, which raises m_valid.
// Only a last byte stalls, and only while the previous result is still untaken.
module status_text_field_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_text_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [stfp_pkg::BYTES_W-1:0]    m_resident_bytes,
    output logic [stfp_pkg::BYTES_W-1:0]    m_peak_resident_bytes,
    output logic [stfp_pkg::THREADS_W-1:0]  m_thread_total,
    output logic                            m_value_overflow
);
    import stfp_pkg::*;

    // Input register
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;

    // Line parser state
    phase_t                phase_reg,  phase_next;
    logic [NUM_KW-1:0]     cand_reg,   cand_next;
    logic [3:0]            pos_reg,    pos_next;
    kw_t                   kw_reg,     kw_next;
    logic [VALUE_BITS-1:0] acc_reg,    acc_next;
    logic                  seen_reg,   seen_next;
    logic [VALUE_BITS-1:0] rss_reg,    rss_next;
    logic [VALUE_BITS-1:0] hwm_reg,    hwm_next;
    logic [VALUE_BITS-1:0] thr_reg,    thr_next;
    logic                  ovf_reg,    ovf_next;

    // Result register
    logic                  m_valid_reg;
    logic [BYTES_W-1:0]    res_rss_reg,  res_rss_next;
    logic [BYTES_W-1:0]    res_hwm_reg,  res_hwm_next;
    logic [THREADS_W-1:0]  res_thr_reg;
    logic                  res_ovf_reg;

    logic                  fire;
    logic                  commit;
    logic [VALUE_BITS-1:0] commit_val;
    logic [ACC_W-1:0]      acc_wide;
    logic                  acc_sat;
    logic [VALUE_BITS+KB_SHIFT-1:0] rss_scaled;
    logic [VALUE_BITS+KB_SHIFT-1:0] hwm_scaled;

    // The held byte advances unless it is a last byte facing a full, stalled result.
    assign fire    = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    // Digit accumulate: value * 10 + digit, saturate when it leaves VALUE_BITS.
    assign acc_wide = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1)
                    + ACC_W'(in_byte_reg - CH_ZERO);
    assign acc_sat  = |acc_wide[ACC_W-1:VALUE_BITS];

    always_comb begin
        logic [NUM_KW-1:0] keep;
        logic              matched;

        phase_next = phase_reg;
        cand_next  = cand_reg;
        pos_next   = pos_reg;
        kw_next    = kw_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        ovf_next   = ovf_reg;
        commit     = 1'b0;
        commit_val = acc_reg;
        keep       = '0;
        matched    = 1'b0;

        if (in_byte_reg == CH_NEWLINE) begin
            // Close the line: store a finished digit run, restart matching.
            commit     = (phase_reg == PH_DIGITS);
            phase_next = PH_MATCH;
            cand_next  = '1;
            pos_next   = '0;
            kw_next    = KW_NONE;
            acc_next   = '0;
            seen_next  = 1'b0;
        end else begin
            case (phase_reg)
                PH_MATCH: begin
                    for (int k = 0; k < NUM_KW; k++) begin
                        if (cand_reg[k] && (pos_reg < KW_LEN[k]) &&
                            (KW_TEXT[k][pos_reg[2:0]] == in_byte_reg)) begin
                            keep[k] = 1'b1;
                            if (pos_reg + 4'd1 == KW_LEN[k]) begin
                                kw_next = kw_t'(2'(k + 1));
                                matched = 1'b1;
                            end
                        end
                    end
                    cand_next = keep;
                    pos_next  = pos_reg + 4'd1;
                    if (matched) begin
                        phase_next = PH_SPACE;
                    end else if (keep == '0) begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SPACE, PH_DIGITS: begin
                    if (is_digit(in_byte_reg)) begin
                        acc_next   = acc_sat ? '1 : acc_wide[VALUE_BITS-1:0];
                        ovf_next   = ovf_reg | acc_sat;
                        seen_next  = 1'b1;
                        phase_next = PH_DIGITS;
                    end else if (!(phase_reg == PH_SPACE && is_blank(in_byte_reg))) begin
                        // Anything after the digit run is ignored.
                        commit     = seen_reg;
                        phase_next = PH_SKIP;
                    end
                end
                default: begin
                end
            endcase
        end

        // Last byte closes an open digit run with the value just updated.
        if (in_last_reg && phase_next == PH_DIGITS) begin
            commit     = 1'b1;
            commit_val = acc_next;
        end

        rss_next = (commit && kw_reg == KW_RSS) ? commit_val : rss_reg;
        hwm_next = (commit && kw_reg == KW_HWM) ? commit_val : hwm_reg;
        thr_next = (commit && kw_reg == KW_THR) ? commit_val : thr_reg;
    end

    assign rss_scaled   = {rss_next, {KB_SHIFT{1'b0}}};
    assign hwm_scaled   = {hwm_next, {KB_SHIFT{1'b0}}};
    assign res_rss_next = BYTES_W'(rss_scaled);
    assign res_hwm_next = BYTES_W'(hwm_scaled);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_text_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Parser state: on a last byte drop everything back to the reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && in_last_reg)) begin
            phase_reg <= PH_MATCH;
            cand_reg  <= '1;
            pos_reg   <= '0;
            kw_reg    <= KW_NONE;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            rss_reg   <= '0;
            hwm_reg   <= '0;
            thr_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            cand_reg  <= cand_next;
            pos_reg   <= pos_next;
            kw_reg    <= kw_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            rss_reg   <= rss_next;
            hwm_reg   <= hwm_next;
            thr_reg   <= thr_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Result register: load on a last byte, hold until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire && in_last_reg) begin
            res_rss_reg <= res_rss_next;
            res_hwm_reg <= res_hwm_next;
            res_thr_reg <= THREADS_W'(thr_next);
            res_ovf_reg <= ovf_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_resident_bytes      = res_rss_reg;
    assign m_peak_resident_bytes = res_hwm_reg;
    assign m_thread_total        = res_thr_reg;
    assign m_value_overflow      = res_ovf_reg;

    // Checks
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> m_valid_reg)
        else $error("last byte did not load a result");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> phase_reg == PH_MATCH && rss_reg == '0 &&
                                hwm_reg == '0 && thr_reg == '0 && !ovf_reg)
        else $error("state not cleared after a text");

    a_match_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_MATCH |-> pos_reg < 4'd8)
        else $error("keyword match ran past the longest keyword");

    a_value_phase_has_kw: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SPACE || phase_reg == PH_DIGITS) |-> kw_reg != KW_NONE)
        else $error("value phase without a matched keyword");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(fire && in_last_reg))
        else $error("pending result overwritten");

endmodule

FILE: dv/stfp_tb_pkg.sv
// Scoreboard for the status text field parser bench: byte-level parse prediction and report check.
// Depends on stfp_pkg for widths, phase and keyword enums.
package stfp_tb_pkg;
    import stfp_pkg::*;

    typedef struct {
        logic [BYTES_W-1:0]   resident;
        logic [BYTES_W-1:0]   peak;
        logic [THREADS_W-1:0] threads;
        logic                 saturated;
    } status_report_t;

    class status_report_board;
        status_report_t expected_reports[$];
        int             mismatches;
        int             reports_checked;
        int             saturated_reports;

        phase_t      phase;
        bit [2:0]    candidates;
        bit [3:0]    position;
        kw_t         keyword;
        bit [63:0]   accum;
        bit          have_digits;
        bit [63:0]   rss_kb;
        bit [63:0]   hwm_kb;
        bit [63:0]   thread_val;
        bit          saturated;
        string       spelling[3];
        kw_t         kw_code[3];

        function new();
            spelling = '{"VmRSS:", "VmHWM:", "Threads:"};
            kw_code  = '{KW_RSS, KW_HWM, KW_THR};
            mismatches = 0;
            reports_checked = 0;
            saturated_reports = 0;
            clear_text();
        endfunction

        function void begin_line();
            phase       = PH_MATCH;
            candidates  = 3'b111;
            position    = '0;
            keyword     = KW_NONE;
            accum       = '0;
            have_digits = 1'b0;
        endfunction

        function void clear_text();
            begin_line();
            rss_kb     = '0;
            hwm_kb     = '0;
            thread_val = '0;
            saturated  = 1'b0;
        endfunction

        function void store_value();
            if (have_digits) begin
                case (keyword)
                    KW_RSS:  rss_kb = accum;
                    KW_HWM:  hwm_kb = accum;
                    KW_THR:  thread_val = accum;
                    default: ;
                endcase
            end
        endfunction

        // Advance the line state by one byte that is not a newline.
        function void parse_byte(bit [7:0] b);
            bit [2:0]  keep;
            bit [63:0] next;
            bit [63:0] ceiling;
            bit        blank;
            int        k;
            keep    = '0;
            ceiling = (64'd1 << VALUE_BITS) - 64'd1;
            case (b)
                8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: blank = 1'b1;
                default: blank = 1'b0;
            endcase
            case (phase)
                PH_MATCH: begin
                    for (k = 0; k < 3; k++) begin
                        if (candidates[k] && position < spelling[k].len()
                                && spelling[k][position] == b) begin
                            keep[k] = 1'b1;
                            if (position + 1 == spelling[k].len()) begin
                                keyword = kw_code[k];
                                phase   = PH_SPACE;
                            end
                        end
                    end
                    candidates = keep;
                    position   = position + 4'd1;
                    if (phase == PH_MATCH && keep == 3'b000) phase = PH_SKIP;
                end
                PH_SPACE, PH_DIGITS: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        next = accum * 64'd10 + {56'd0, b - CH_ZERO};
                        if (next > ceiling) begin
                            next      = ceiling;
                            saturated = 1'b1;
                        end
                        accum       = next;
                        have_digits = 1'b1;
                        phase       = PH_DIGITS;
                    end else if (!(phase == PH_SPACE && blank)) begin
                        store_value();
                        phase = PH_SKIP;
                    end
                end
                default: ;
            endcase
        endfunction

        function void accept_byte(bit [7:0] b, bit last);
            status_report_t rep;
            bit [63:0]      scaled;
            if (b == CH_NEWLINE) begin
                if (phase == PH_DIGITS) store_value();
                begin_line();
            end else begin
                parse_byte(b);
            end
            if (last) begin
                if (phase == PH_DIGITS) store_value();
                scaled        = rss_kb * 64'd1024;
                rep.resident  = scaled[BYTES_W-1:0];
                scaled        = hwm_kb * 64'd1024;
                rep.peak      = scaled[BYTES_W-1:0];
                rep.threads   = thread_val[THREADS_W-1:0];
                rep.saturated = saturated;
                expected_reports.push_back(rep);
                clear_text();
            end
        endfunction

        function void check_report(logic [BYTES_W-1:0] resident, logic [BYTES_W-1:0] peak,
                                   logic [THREADS_W-1:0] threads, logic saturated_flag);
            status_report_t want;
            if (expected_reports.size() == 0) begin
                $error("report with no closed text: resident_bytes %0d", resident);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            if (want.saturated) saturated_reports++;
            if (resident !== want.resident) begin
                $error("resident_bytes: expected %0d, actual %0d", want.resident, resident);
                mismatches++;
            end
            if (peak !== want.peak) begin
                $error("peak_resident_bytes: expected %0d, actual %0d", want.peak, peak);
                mismatches++;
            end
            if (threads !== want.threads) begin
                $error("thread_total: expected %0d, actual %0d", want.threads, threads);
                mismatches++;
            end
            if (saturated_flag !== want.saturated) begin
                $error("value_overflow: expected %0d, actual %0d", want.saturated,
                       saturated_flag);
                mismatches++;
            end
        endfunction
    endclass

endpackage

FILE: dv/tb_top.sv
// Top-level bench for status_text_field_parser: drives status texts byte by byte and
// checks every report against the scoreboard in stfp_tb_pkg. Depends on stfp_pkg and stfp_tb_pkg.
module tb_top;
    import stfp_pkg::*;
    import stfp_tb_pkg::*;

    // Cycles without any accepted request on either side before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_BYTES = 1900;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_text_byte = 8'h00;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTES_W-1:0]   m_resident_bytes;
    logic [BYTES_W-1:0]   m_peak_resident_bytes;
    logic [THREADS_W-1:0] m_thread_total;
    logic                 m_value_overflow;

    status_report_board sb = new();

    bit [7:0] text_q[$];          // bytes of the text being built
    bit       gapless;            // sender runs back to back for the current text
    bit       hold_done;          // receiver hold-off already spent
    int       texts_sent;
    int       bytes_sent;
    int       quiet_cycles;

    status_text_field_parser DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_text_byte           (s_text_byte),
        .s_last_byte           (s_last_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_resident_bytes      (m_resident_bytes),
        .m_peak_resident_bytes (m_peak_resident_bytes),
        .m_thread_total        (m_thread_total),
        .m_value_overflow      (m_value_overflow)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: mostly none, otherwise a short gap or, now and then, a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------------------------
    // Text building: keyword lines with random blanks, digit runs and trailers, plus
    // noise lines and near misses of the keywords.
    // ---------------------------------------------------------------------------------
    function automatic void push_word(string w);
        int i;
        for (i = 0; i < w.len(); i++) text_q.push_back(w[i]);
    endfunction

    function automatic void push_blanks(int n);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0:       text_q.push_back(8'h09);
                1:       text_q.push_back(8'h0B);
                2:       text_q.push_back(8'h0C);
                3:       text_q.push_back(8'h0D);
                default: text_q.push_back(8'h20);
            endcase
        end
    endfunction

    function automatic void push_digits(int n);
        repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic string pick_keyword();
        case ($urandom_range(0, 2))
            0:       return "VmRSS:";
            1:       return "VmHWM:";
            default: return "Threads:";
        endcase
    endfunction

    function automatic void push_field_line();
        int r;
        push_word(pick_keyword());
        if ($urandom_range(0, 3) != 0) push_blanks($urandom_range(1, 4));
        r = $urandom_range(0, 99);
        // Drop the digits now and then: such a line must leave the stored value alone.
        if (r >= 10) begin
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
            // Long runs can reach past the accumulator width and saturate.
            if (r < 25) push_digits($urandom_range(11, 18));
            else        push_digits($urandom_range(1, 7));
        end
        case ($urandom_range(0, 5))
            0: push_word(" kB");
            1: text_q.push_back(8'($urandom_range(0, 255)));
            2: begin
                push_blanks(1);
                push_digits($urandom_range(1, 3));
            end
            default: ;
        endcase
    endfunction

    function automatic void push_noise_line();
        string w;
        int    i, cut;
        w = pick_keyword();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(0, 255)));
            1: begin
                // Keyword with one byte replaced by a random one.
                cut = $urandom_range(0, w.len() - 1);
                for (i = 0; i < w.len(); i++)
                    text_q.push_back((i == cut) ? 8'($urandom_range(0, 255)) : w[i]);
                push_digits($urandom_range(1, 4));
            end
            2: begin
                // Keyword cut short before its colon.
                cut = $urandom_range(0, w.len() - 1);
                for (i = 0; i < cut; i++) text_q.push_back(w[i]);
                push_digits(2);
            end
            default: begin
                // Keyword not at line start.
                push_blanks(1);
                push_word(w);
                push_digits(3);
            end
        endcase
    endfunction

    function automatic void build_text();
        int lines, i;
        text_q.delete();
        lines = $urandom_range(1, 4);
        for (i = 0; i < lines; i++) begin
            if ($urandom_range(0, 3) != 0) push_field_line();
            else                           push_noise_line();
            // The final line closes either on its newline or on its own last byte.
            if (i < lines - 1 || $urandom_range(0, 1) == 0) text_q.push_back(CH_NEWLINE);
        end
        if (text_q.size() == 0) text_q.push_back(CH_NEWLINE);
    endfunction

    // ---------------------------------------------------------------------------------
    // Sender: hold each request until accepted, then note it in the scoreboard.
    // Called at a rising edge; valid gets exactly one assignment per time step.
    // ---------------------------------------------------------------------------------
    task automatic offer_byte(input logic [7:0] b, input logic last);
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        sb.accept_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_text();
        int i, gap;
        for (i = 0; i < text_q.size(); i++) begin
            offer_byte(text_q[i], i == text_q.size() - 1);
            gap = gapless ? 0 : idle_len();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        texts_sent++;
    endtask

    initial begin : stimulus
        int i;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: an empty text closed by its newline.
        gapless = 1'b1;
        text_q.delete();
        text_q.push_back(CH_NEWLINE);
        send_text();

        // Directed: thread count far past the accumulator width, closed on its last digit.
        text_q.delete();
        push_word("Threads:");
        repeat (13) text_q.push_back(CH_NINE);
        send_text();

        // Directed: extreme byte values, the last one closing an unmatched line.
        gapless = 1'b0;
        text_q.delete();
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        send_text();

        // Random texts; one in four goes back to back with no sender gaps.
        while (bytes_sent < TARGET_BYTES) begin
            gapless = ($urandom_range(0, 3) == 0);
            build_text();
            send_text();
        end
        s_valid <= 1'b0;

        // Drain: wait for every pending report, then a short tail for strays.
        while (sb.expected_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d texts in %0d bytes; checked %0d reports, %0d with saturated values.",
                 texts_sent, bytes_sent, sb.reports_checked, sb.saturated_reports);
        if (sb.mismatches == 0) begin
            $display("[status_text_field_parser] OK");
        end else begin
            $display("[status_text_field_parser] ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Receiver: random ready with runs of both levels. Once, after a few reports, hold
    // ready low for a long stretch so the result register fills and the input stalls.
    // ---------------------------------------------------------------------------------
    initial begin : result_sink
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!hold_done && sb.reports_checked >= 8) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (idle_len() + 1) @(posedge aclk);
            end
        end
    end

    // Check every accepted report request against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_report(m_resident_bytes, m_peak_resident_bytes, m_thread_total,
                            m_value_overflow);
    end

    // Watchdog: count cycles with no request moving on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request accepted for %0d cycles.", STALL_LIMIT);
                $display("[status_text_field_parser] ERROR");
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
rtl/core/stfp_pkg.sv
rtl/core/status_text_field_parser.sv
dv/stfp_tb_pkg.sv
dv/tb_top.sv
